// ----- sv/g16frc_pkg.sv -----
// Shared types, constants and the dither lookup for the gray16 frame rate control block.
`timescale 1ns / 1ps

package g16frc_pkg;

    localparam int PIXEL_COUNT = 8;
    localparam int GRAY_W      = 4;
    localparam int LEVEL_W     = 2;
    localparam int PAGE_W      = 3;
    localparam int PAGE_COUNT  = 5;
    localparam int GRAY_LEVELS = 16;

    localparam logic [PAGE_W-1:0] FIRST_PAGE = 3'd0;
    localparam logic [PAGE_W-1:0] LAST_PAGE  = 3'd4;

    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [GRAY_W-1:0]  gray_t;
    typedef logic [LEVEL_W-1:0] level_t;

    typedef struct packed {
        logic [PIXEL_COUNT-1:0] plane_high;
        logic [PIXEL_COUNT-1:0] plane_low;
        page_t                  page_used;
    } result_t;

    localparam level_t DITHER_TABLE [PAGE_COUNT][GRAY_LEVELS] = '{
        '{2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1,
          2'd2, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd3},
        '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2,
          2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3},
        '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
          2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3},
        '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2,
          2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3},
        '{2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1,
          2'd2, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3}
    };

    function automatic level_t dither_level(input page_t page, input gray_t gray);
        level_t lvl;
        case (page)
            3'd0:    lvl = DITHER_TABLE[0][gray];
            3'd1:    lvl = DITHER_TABLE[1][gray];
            3'd2:    lvl = DITHER_TABLE[2][gray];
            3'd3:    lvl = DITHER_TABLE[3][gray];
            3'd4:    lvl = DITHER_TABLE[4][gray];
            default: lvl = DITHER_TABLE[0][gray];
        endcase
        return lvl;
    endfunction

endpackage

// ----- sv/g16frc_lane.sv -----
// One dither lane: maps a single 16-level gray pixel to its 2-bit level on the current page.
`timescale 1ns / 1ps

module g16frc_lane
    import g16frc_pkg::*;
(
    input  page_t  page,
    input  gray_t  gray,
    output level_t level
);

    assign level = dither_level(page, gray);

endmodule

// ----- sv/g16frc_merge.sv -----
// Merge stage: applies the overlay over the lane levels and splits them into two bit planes.
`timescale 1ns / 1ps

module g16frc_merge
    import g16frc_pkg::*;
(
    input  logic [PIXEL_COUNT-1:0][LEVEL_W-1:0] lane_levels,
    input  logic                                overlay_enable,
    input  logic [PIXEL_COUNT*LEVEL_W-1:0]      overlay_levels,
    input  logic [PIXEL_COUNT-1:0]              overlay_transparent,
    output logic [PIXEL_COUNT-1:0]              plane_high,
    output logic [PIXEL_COUNT-1:0]              plane_low
);

    level_t merged [PIXEL_COUNT];

    always_comb
    begin
        for (int k = 0; k < PIXEL_COUNT; k++)
        begin
            if (overlay_enable && !overlay_transparent[k])
            begin
                merged[k] = overlay_levels[k*LEVEL_W +: LEVEL_W];
            end
            else
            begin
                merged[k] = lane_levels[k];
            end
            plane_high[k] = merged[k][1];
            plane_low[k]  = merged[k][0];
        end
    end

endmodule

// ----- sv/g16frc_outbuf.sv -----
// Output register with a skid entry so the input side keeps flowing while a result waits.
`timescale 1ns / 1ps

module g16frc_outbuf
    import g16frc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_stall,
    input  result_t push_data,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    main_valid_next;
    result_t main_data_reg;
    result_t main_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    push_accept;
    logic    main_free;

    assign push_stall  = skid_valid_reg;
    assign push_accept = push_valid && !skid_valid_reg;
    assign main_free   = !main_valid_reg || !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push_accept;
                main_data_next  = push_data;
            end
        end
        else if (push_accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

`ifndef SYNTHESIS
    a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without a main entry");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && out_stall))
        else $error("skid entry filled while output was free");

    a_skid_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid entry lost while output stalled");
`endif

endmodule

// ----- sv/gray16_frame_rate_control.sv -----
// Top level of the gray16 frame rate control: page state, eight dither lanes, merge, output buffer.
`timescale 1ns / 1ps

// Temporal grayscale dither for a 4-level LCD. Every item carries eight 16-level
// gray pixels; eight lanes look them up in the dither table row of the current
// page (0..4) in the same cycle, the merge stage lays the optional overlay over
// them and splits the result into two bit-plane bytes. An item is taken every
// cycle while in_stall is low; its result goes to the output register, or to the
// skid entry while the output is stalled, so the two-entry output buffer keeps
// the input flowing for one more item. The page advances after each item flagged
// end_of_frame. overlay_enable is written through cfg_write_en and cfg_write_data,
// and the user must do so only while the block is idle; the block does not enforce it.
module gray16_frame_rate_control
    import g16frc_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic                           cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [PIXEL_COUNT*GRAY_W-1:0]  gray_pixels,
    input  logic [PIXEL_COUNT*LEVEL_W-1:0] overlay_levels,
    input  logic [PIXEL_COUNT-1:0]         overlay_transparent,
    input  logic                           end_of_frame,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [PIXEL_COUNT-1:0]         plane_high,
    output logic [PIXEL_COUNT-1:0]         plane_low,
    output logic [PAGE_W-1:0]              page_used
);

    logic                               overlay_enable_reg;
    logic                               overlay_enable_next;
    page_t                              page_reg;
    page_t                              page_next;
    page_t                              page_cur;
    logic                               in_accept;
    logic [PIXEL_COUNT-1:0][LEVEL_W-1:0] lane_levels;
    logic [PIXEL_COUNT-1:0]             new_plane_high;
    logic [PIXEL_COUNT-1:0]             new_plane_low;
    result_t                            new_result;
    result_t                            out_result;

    assign in_accept = in_valid && !in_stall;
    assign page_cur  = (page_reg > LAST_PAGE) ? FIRST_PAGE : page_reg;

    always_comb
    begin
        overlay_enable_next = cfg_write_en ? cfg_write_data : overlay_enable_reg;
        page_next           = page_reg;
        if (in_accept && end_of_frame)
        begin
            page_next = (page_cur == LAST_PAGE) ? FIRST_PAGE : page_cur + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlay_enable_reg <= 1'b0;
            page_reg           <= FIRST_PAGE;
        end
        else
        begin
            overlay_enable_reg <= overlay_enable_next;
            page_reg           <= page_next;
        end
    end

    for (genvar k = 0; k < PIXEL_COUNT; k++)
    begin : g_lane
        g16frc_lane u_lane (
            .page  (page_cur),
            .gray  (gray_pixels[k*GRAY_W +: GRAY_W]),
            .level (lane_levels[k])
        );
    end

    g16frc_merge u_merge (
        .lane_levels         (lane_levels),
        .overlay_enable      (overlay_enable_reg),
        .overlay_levels      (overlay_levels),
        .overlay_transparent (overlay_transparent),
        .plane_high          (new_plane_high),
        .plane_low           (new_plane_low)
    );

    assign new_result = '{plane_high: new_plane_high, plane_low: new_plane_low,
                          page_used: page_cur};

    g16frc_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_stall (in_stall),
        .push_data  (new_result),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_result)
    );

    assign plane_high = out_result.plane_high;
    assign plane_low  = out_result.plane_low;
    assign page_used  = out_result.page_used;

`ifndef SYNTHESIS
    a_page_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        page_reg <= LAST_PAGE)
        else $error("dither page out of range");

    a_page_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && end_of_frame && page_reg == LAST_PAGE) |=> page_reg == FIRST_PAGE)
        else $error("dither page did not wrap");

    a_page_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && end_of_frame && page_reg < LAST_PAGE)
        |=> page_reg == $past(page_reg) + 3'd1)
        else $error("dither page did not advance");

    a_page_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && end_of_frame) |=> $stable(page_reg))
        else $error("dither page changed mid frame");
`endif

endmodule

// ----- dv/tb_gray16_frame_rate_control.sv -----
// Self-checking testbench for gray16_frame_rate_control: directed table, random frames, scoreboard.
`timescale 1ns / 1ps

module tb_gray16_frame_rate_control
    import g16frc_pkg::*;
();

    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 204;
    localparam int STEADY_PHASE   = 3;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic        ovl_en;
        logic [31:0] gray;
        logic [15:0] ovl;
        logic [7:0]  transp;
        logic        eof;
        logic        typed;
        result_t     want;
    } frc_row_t;

    logic        clk;
    logic        rst_n               = 1'b0;
    logic        cfg_write_en        = 1'b0;
    logic        cfg_write_data      = 1'b0;
    logic        in_valid            = 1'b0;
    logic        in_stall;
    logic [31:0] gray_pixels         = '0;
    logic [15:0] overlay_levels      = '0;
    logic [7:0]  overlay_transparent = '0;
    logic        end_of_frame        = 1'b0;
    logic        out_valid;
    logic        out_stall           = 1'b0;
    logic [7:0]  plane_high;
    logic [7:0]  plane_low;
    logic [2:0]  page_used;

    result_t  planes_expected_q [$];
    frc_row_t directed_q [$];
    page_t    model_page    = FIRST_PAGE;
    logic     model_overlay = 1'b0;
    logic     steady        = 1'b0;
    int       mismatches    = 0;
    int       items_sent    = 0;
    int       frames_done   = 0;
    int       merged_items  = 0;
    int       results_seen  = 0;
    int       idle_cycles   = 0;

    gray16_frame_rate_control u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write_en        (cfg_write_en),
        .cfg_write_data      (cfg_write_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .gray_pixels         (gray_pixels),
        .overlay_levels      (overlay_levels),
        .overlay_transparent (overlay_transparent),
        .end_of_frame        (end_of_frame),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .plane_high          (plane_high),
        .plane_low           (plane_low),
        .page_used           (page_used)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [1:0] frc_level(input page_t page, input logic [3:0] gray);
        logic [0:15][1:0] row;
        case (page)
            3'd1:    row = {2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2,
                            2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
            3'd2:    row = {2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
                            2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};
            3'd3:    row = {2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2,
                            2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
            3'd4:    row = {2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1,
                            2'd2, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3};
            default: row = {2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1,
                            2'd2, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd3};
        endcase
        return row[gray];
    endfunction

    function automatic result_t predict_planes(input logic [31:0] gray, input logic [15:0] ovl,
                                               input logic [7:0] transp);
        result_t    res;
        logic [1:0] lvl;
        res.page_used = (model_page > LAST_PAGE) ? FIRST_PAGE : model_page;
        for (int k = 0; k < 8; k++)
        begin
            lvl = frc_level(res.page_used, gray[4*k +: 4]);
            if (model_overlay && !transp[k])
                lvl = ovl[2*k +: 2];
            res.plane_high[k] = lvl[1];
            res.plane_low[k]  = lvl[0];
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_gray();
        logic [3:0] g;
        g = 4'($urandom_range(15));
        case ($urandom_range(9))
            0:       return {8{g}};
            1:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_transp();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_row(input logic ovl_en, input logic [31:0] gray, input logic [15:0] ovl,
                           input logic [7:0] transp, input logic eof, input logic typed,
                           input logic [7:0] hi, input logic [7:0] lo, input page_t page);
        frc_row_t r;
        r.ovl_en = ovl_en;
        r.gray   = gray;
        r.ovl    = ovl;
        r.transp = transp;
        r.eof    = eof;
        r.typed  = typed;
        r.want   = '{plane_high: hi, plane_low: lo, page_used: page};
        directed_q.push_back(r);
    endtask

    task automatic send_item(input logic [31:0] gray, input logic [15:0] ovl,
                             input logic [7:0] transp, input logic eof, input logic typed,
                             input result_t want);
        result_t pred;
        while (!steady && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid            <= 1'b1;
        gray_pixels         <= gray;
        overlay_levels      <= ovl;
        overlay_transparent <= transp;
        end_of_frame        <= eof;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = predict_planes(gray, ovl, transp);
        planes_expected_q.push_back(typed ? want : pred);
        items_sent++;
        if (model_overlay)
            merged_items++;
        if (eof)
        begin
            frames_done++;
            model_page = (pred.page_used == LAST_PAGE) ? FIRST_PAGE : pred.page_used + 3'd1;
        end
        else
            model_page = pred.page_used;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (planes_expected_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_overlay(input logic en);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= en;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        model_overlay = en;
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (planes_expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result hi=%h lo=%h page=%0d",
                         $time, plane_high, plane_low, page_used);
            end
            else
            begin
                want = planes_expected_q.pop_front();
                if (plane_high !== want.plane_high)
                begin
                    mismatches++;
                    $display("%0t: plane_high expected %h actual %h",
                             $time, want.plane_high, plane_high);
                end
                if (plane_low !== want.plane_low)
                begin
                    mismatches++;
                    $display("%0t: plane_low expected %h actual %h",
                             $time, want.plane_low, plane_low);
                end
                if (page_used !== want.page_used)
                begin
                    mismatches++;
                    $display("%0t: page_used expected %0d actual %0d",
                             $time, want.page_used, page_used);
                end
            end
        end
        out_stall <= !steady && ($urandom_range(99) < 33);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        result_t none;
        logic    en;
        logic    eof;
        none = '0;

        // overlay off: ignored overlay, then every page over all 16 levels
        add_row(1'b0, 32'h0000_0000, 16'h0000, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 3'd0);
        add_row(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 8'h00, 1'b0, 1'b1, 8'hFF, 8'hFF, 3'd0);
        for (int p = 0; p < 5; p++)
        begin
            add_row(1'b0, 32'h7654_3210, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 3'd0);
            add_row(1'b0, 32'hFEDC_BA98, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 3'd0);
        end
        add_row(1'b0, 32'h0000_0000, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 8'h00, 8'h00, 3'd0);
        // overlay on: opaque, fully transparent, mixed; then one row with overlay off again
        add_row(1'b1, 32'h0000_0000, 16'hFFFF, 8'h00, 1'b0, 1'b1, 8'hFF, 8'hFF, 3'd0);
        add_row(1'b1, 32'hFFFF_FFFF, 16'h0000, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 3'd0);
        add_row(1'b1, 32'hFFFF_FFFF, 16'h0000, 8'hFF, 1'b0, 1'b1, 8'hFF, 8'hFF, 3'd0);
        add_row(1'b1, 32'h0000_0000, 16'hE4E4, 8'h00, 1'b0, 1'b1, 8'hCC, 8'hAA, 3'd0);
        add_row(1'b1, 32'h5A5A_5A5A, 16'hAAAA, 8'h55, 1'b1, 1'b0, 8'h00, 8'h00, 3'd0);
        add_row(1'b1, 32'hF0F0_F0F0, 16'h5555, 8'hAA, 1'b0, 1'b0, 8'h00, 8'h00, 3'd0);
        add_row(1'b0, 32'h1234_5678, 16'hFFFF, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 3'd0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_overlay(1'b0);

        foreach (directed_q[i])
        begin
            if (directed_q[i].ovl_en != model_overlay)
            begin
                settle();
                write_overlay(directed_q[i].ovl_en);
            end
            send_item(directed_q[i].gray, directed_q[i].ovl, directed_q[i].transp,
                      directed_q[i].eof, directed_q[i].typed, directed_q[i].want);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            en = (ph % 2 == 0) ? 1'b1 : 1'b0;
            write_overlay(en);
            steady = (ph == STEADY_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (!steady && $urandom_range(99) == 0)
                    settle();
                eof = ($urandom_range(20) == 0) ? 1'b1 : ($urandom_range(7) == 0);
                send_item(rand_gray(), 16'($urandom_range(65535)), rand_transp(), eof,
                          1'b0, none);
            end
            steady = 1'b0;
        end

        settle();
        repeat (4) @(posedge clk);
        $display("Covered %0d items over %0d frames, %0d with overlay merged.",
                 items_sent, frames_done, merged_items);
        $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
